// ===== rtl/tmrle_pkg.sv =====
package tmrle_pkg;

  // Default geometry
  localparam int COLUMNS_DEFAULT    = 64;
  localparam int MAX_TABLES_DEFAULT = 4;

  // Field widths fixed by the stream format
  localparam int WORD_W  = 16;
  localparam int ADDR_W  = 16;
  localparam int ROWS_W  = 8;
  localparam int TCNT_W  = 3;
  localparam int COUNT_W = WORD_W + 1;   // run count is word + 1
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [ADDR_W-1:0] DEST_BASE_RST      = 16'd3968;
  localparam logic [ROWS_W-1:0] ROWS_PER_TABLE_RST = 8'd32;
  localparam logic [TCNT_W-1:0] TABLE_COUNT_RST    = 3'd4;

  // Address steps
  localparam logic [ADDR_W-1:0] TILE_STEP    = 16'h0002;
  localparam logic [ADDR_W-1:0] ROW_STEP     = 16'h0100;
  localparam int                TABLE_SHIFT  = 12;        // tables 0x1000 apart

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_BASE      = 2'd0,
    REG_ROWS_PER_TABLE = 2'd1,
    REG_TABLE_COUNT    = 2'd2
  } cfg_reg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // take the input beat
    logic emit;     // produce one tile write into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit_start;  // the offered beat causes at least one write
    logic last;        // the write being produced ends this beat's writes
  } dp_stat_t;

endpackage

// ===== rtl/tilemap_rle_nametable_loader_core.sv =====
// Tilemap run-length decoder: turns a stream of compressed ROM words into
// tile-RAM writes.
// Input beats (s_axis_*): one ROM word each; tuser set restarts the map at
// dest_base before that word. A nonzero word gives one write; a zero word,
// a value word and a count word give count+1 writes of the value, cut at
// the end of a row. Words after the map is complete give no writes.
// Output beats (m_axis_*): one tile write each, tdata = {value, address};
// tlast marks the final write of an input word, tuser the final write of
// the whole map.
// Timing: each word is decoded in the cycle that it is taken. A word that
// gives writes then produces one write per cycle into the output register
// while the receiver is ready, at most COLUMNS writes per word. The next word is
// taken in the cycle after the last write is produced, even while that
// write still waits in the output register.
// A stalled receiver holds the current write and pauses the run.
// cfg_*: register writes, always ready; write only while no run is active.
// Reset: registers to their defaults, decoder at the first row of table 0.
module tilemap_rle_nametable_loader_core #(
  parameter int COLUMNS    = tmrle_pkg::COLUMNS_DEFAULT,
  parameter int MAX_TABLES = tmrle_pkg::MAX_TABLES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [15:0] rom_word
  input  logic                            s_axis_tuser,  // [0] start_map
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // [15:0] tile_addr, [31:16] tile_value
  output logic                            m_axis_tlast,  // last_of_run
  output logic                            m_axis_tuser,  // [0] map_done
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmrle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmrle_pkg::WORD_W-1:0]    cfg_data
);
  import tmrle_pkg::*;

  dp_cmd_t           cmd;
  dp_stat_t          st;
  logic [ADDR_W-1:0] out_addr;
  logic [WORD_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  // Sequencer
  tmrle_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .st      (st),
    .cmd     (cmd)
  );

  // Decoder datapath
  tmrle_dp #(
    .COLUMNS    (COLUMNS),
    .MAX_TABLES (MAX_TABLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_addr  (out_addr),
    .out_value (out_value),
    .out_last  (m_axis_tlast),
    .out_done  (m_axis_tuser)
  );

  assign m_axis_tdata = {out_value, out_addr};

  // The map can only complete on the last write of a beat
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("map_done without last_of_run");

  // A beat that starts writes blocks the input until its run ends
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && st.emit_start |=> !s_axis_tready)
    else $error("input taken while a run is pending");

  // The final write of a run frees the input in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && st.last |=> s_axis_tready)
    else $error("input not released after final write");

  // Accept and emit never coincide
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.accept && cmd.emit))
    else $error("accept and emit in the same cycle");

endmodule

// ===== rtl/tmrle_ctrl.sv =====
module tmrle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  logic               m_ready,
  output logic               m_valid,
  input  tmrle_pkg::dp_stat_t st,
  output tmrle_pkg::dp_cmd_t  cmd
);
  import tmrle_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t state;

  // Handshake and commands
  assign s_ready    = (state == ST_IDLE);
  assign cmd.accept = (state == ST_IDLE) && s_valid;
  assign cmd.emit   = (state == ST_EMIT) && (!m_valid || m_ready);

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.accept && st.emit_start) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.emit && st.last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tmrle_dp.sv =====
module tmrle_dp #(
  parameter int COLUMNS    = tmrle_pkg::COLUMNS_DEFAULT,
  parameter int MAX_TABLES = tmrle_pkg::MAX_TABLES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tmrle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmrle_pkg::WORD_W-1:0]    cfg_data,
  input  logic [tmrle_pkg::WORD_W-1:0]    in_word,
  input  logic                            in_start,
  input  tmrle_pkg::dp_cmd_t              cmd,
  output tmrle_pkg::dp_stat_t             st,
  output logic [tmrle_pkg::ADDR_W-1:0]    out_addr,
  output logic [tmrle_pkg::WORD_W-1:0]    out_value,
  output logic                            out_last,
  output logic                            out_done
);
  import tmrle_pkg::*;

  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int TI_W  = $clog2(MAX_TABLES + 1);
  localparam int LIM_W = (TI_W > TCNT_W) ? TI_W : TCNT_W;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_VALUE,
    PH_COUNT
  } phase_t;

  // Configuration registers
  logic [ADDR_W-1:0] dest_base;
  logic [ROWS_W-1:0] rows_per_table;
  logic [TCNT_W-1:0] table_count;

  // Decoder state
  phase_t             phase, phase_next;
  logic [WORD_W-1:0]  run_value, run_value_next;
  logic [COL_W-1:0]   columns_left, columns_left_next;
  logic [ROWS_W-1:0]  rows_left, rows_left_next;
  logic [TI_W-1:0]    table_index, table_index_next;
  logic [ADDR_W-1:0]  write_addr, write_addr_next;
  logic               finished, finished_next;
  logic               fresh, fresh_next;
  logic [COUNT_W-1:0] count, count_next;

  logic [ROWS_W-1:0] eff_rows;
  logic [LIM_W-1:0]  tc_lim;
  logic [TI_W-1:0]   eff_tables;
  phase_t            eff_phase;
  logic              eff_finished;
  logic [ADDR_W-1:0] addr_inc;
  logic [TI_W-1:0]   ti_inc;
  logic              row_end;
  logic              map_end;

  // Effective limits: zero rows act as one, table count clamped to 1..MAX_TABLES
  assign eff_rows = (rows_per_table == '0) ? ROWS_W'(1) : rows_per_table;
  always_comb begin
    if (table_count == '0) begin
      tc_lim = LIM_W'(1);
    end else if (LIM_W'(table_count) > LIM_W'(MAX_TABLES)) begin
      tc_lim = LIM_W'(MAX_TABLES);
    end else begin
      tc_lim = LIM_W'(table_count);
    end
  end
  assign eff_tables = TI_W'(tc_lim);

  // Beat decode as seen after an optional restart
  assign eff_phase    = in_start ? PH_TOKEN : phase;
  assign eff_finished = in_start ? 1'b0 : finished;
  assign st.emit_start = !eff_finished &&
                         ((eff_phase == PH_COUNT) ||
                          ((eff_phase == PH_TOKEN) && (in_word != '0)));

  // One write step
  assign addr_inc = write_addr + TILE_STEP;
  assign ti_inc   = table_index + TI_W'(1);
  assign row_end  = (columns_left == COL_W'(1));
  assign map_end  = row_end && (rows_left == ROWS_W'(1)) && (ti_inc >= eff_tables);
  assign st.last  = row_end || (count == COUNT_W'(1));

  // Next state
  always_comb begin
    phase_next        = phase;
    run_value_next    = run_value;
    columns_left_next = columns_left;
    rows_left_next    = rows_left;
    table_index_next  = table_index;
    write_addr_next   = write_addr;
    finished_next     = finished;
    fresh_next        = fresh;
    count_next        = count;

    if (cmd.accept) begin
      if (in_start) begin
        phase_next        = PH_TOKEN;
        run_value_next    = '0;
        columns_left_next = COL_W'(COLUMNS);
        rows_left_next    = eff_rows;
        table_index_next  = '0;
        write_addr_next   = dest_base;
        finished_next     = 1'b0;
        fresh_next        = 1'b1;
      end
      if (!eff_finished) begin
        fresh_next = 1'b0;
        case (eff_phase)
          PH_VALUE: begin
            run_value_next = in_word;
            phase_next     = PH_COUNT;
          end
          PH_COUNT: begin
            phase_next = PH_TOKEN;
            count_next = COUNT_W'(in_word) + COUNT_W'(1);
          end
          default: begin
            if (in_word == '0) begin
              phase_next = PH_VALUE;
            end else begin
              run_value_next = in_word;
              count_next     = COUNT_W'(1);
            end
          end
        endcase
      end
    end

    if (cmd.emit) begin
      count_next        = count - COUNT_W'(1);
      columns_left_next = columns_left - COL_W'(1);
      write_addr_next   = addr_inc;
      if (row_end) begin
        columns_left_next = COL_W'(COLUMNS);
        write_addr_next   = addr_inc - ROW_STEP;
        rows_left_next    = rows_left - ROWS_W'(1);
        if (rows_left == ROWS_W'(1)) begin
          table_index_next = ti_inc;
          if (ti_inc >= eff_tables) begin
            finished_next = 1'b1;
          end else begin
            rows_left_next  = eff_rows;
            write_addr_next = dest_base + (ADDR_W'(ti_inc) << TABLE_SHIFT);
          end
        end
      end
    end

    // Before the first beat, base and row writes also move the start point
    if (cfg_we && fresh) begin
      case (cfg_index)
        REG_DEST_BASE:      write_addr_next = cfg_data;
        REG_ROWS_PER_TABLE: begin
          if (cfg_data[ROWS_W-1:0] == '0) begin
            rows_left_next = ROWS_W'(1);
          end else begin
            rows_left_next = cfg_data[ROWS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TOKEN;
      run_value    <= '0;
      columns_left <= COL_W'(COLUMNS);
      rows_left    <= ROWS_PER_TABLE_RST;
      table_index  <= '0;
      write_addr   <= DEST_BASE_RST;
      finished     <= 1'b0;
      fresh        <= 1'b1;
      count        <= '0;
    end else begin
      phase        <= phase_next;
      run_value    <= run_value_next;
      columns_left <= columns_left_next;
      rows_left    <= rows_left_next;
      table_index  <= table_index_next;
      write_addr   <= write_addr_next;
      finished     <= finished_next;
      fresh        <= fresh_next;
      count        <= count_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_base      <= DEST_BASE_RST;
      rows_per_table <= ROWS_PER_TABLE_RST;
      table_count    <= TABLE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEST_BASE:      dest_base      <= cfg_data;
        REG_ROWS_PER_TABLE: rows_per_table <= cfg_data[ROWS_W-1:0];
        REG_TABLE_COUNT:    table_count    <= cfg_data[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_addr  <= write_addr;
      out_value <= run_value;
      out_last  <= st.last;
      out_done  <= map_end;
    end
  end

endmodule

// ===== verif/tile_write_checker.sv =====
module tile_write_checker #(
  parameter int COLUMNS    = tmrle_pkg::COLUMNS_DEFAULT,
  parameter int MAX_TABLES = tmrle_pkg::MAX_TABLES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tmrle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmrle_pkg::WORD_W-1:0]    cfg_data,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [15:0] rom_word
  input  logic                            s_axis_tuser,  // [0] start_map
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [31:0]                     m_axis_tdata,  // [15:0] tile_addr, [31:16] tile_value
  input  logic                            m_axis_tlast,  // last_of_run
  input  logic                            m_axis_tuser,  // [0] map_done
  output int                              fail_count,
  output int                              writes_pending,
  output int                              writes_checked
);
  import tmrle_pkg::*;

  typedef enum logic [1:0] {
    EXPECT_TOKEN,
    EXPECT_VALUE,
    EXPECT_COUNT
  } decode_phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] value;
    logic              last;
    logic              done;
  } tile_write_t;

  // Register copies
  logic [ADDR_W-1:0] base_addr;
  logic [ROWS_W-1:0] rows_cfg;
  logic [TCNT_W-1:0] tables_cfg;

  // Decoder state
  decode_phase_t     phase;
  logic [WORD_W-1:0] held_tile;
  int                cols_left;
  int                rows_left;
  int                table_idx;
  logic [ADDR_W-1:0] wr_addr;
  bit                map_finished;
  bit                untouched;    // no word taken since reset or restart

  tile_write_t expected_writes[$];
  int          mismatch_cnt = 0;
  int          checked_cnt  = 0;

  function automatic int rows_in_table();
    return (rows_cfg == '0) ? 1 : int'(rows_cfg);
  endfunction

  function automatic int tables_in_map();
    if (tables_cfg == '0) return 1;
    if (int'(tables_cfg) > MAX_TABLES) return MAX_TABLES;
    return int'(tables_cfg);
  endfunction

  function automatic void restart_map();
    phase        = EXPECT_TOKEN;
    held_tile    = '0;
    cols_left    = COLUMNS;
    rows_left    = rows_in_table();
    table_idx    = 0;
    wr_addr      = base_addr;
    map_finished = 1'b0;
    untouched    = 1'b1;
  endfunction

  function automatic void apply_reg_write(cfg_reg_t idx, logic [WORD_W-1:0] d);
    case (idx)
      REG_DEST_BASE: begin
        base_addr = d;
        if (untouched) wr_addr = base_addr;
      end
      REG_ROWS_PER_TABLE: begin
        rows_cfg = d[ROWS_W-1:0];
        if (untouched) rows_left = rows_in_table();
      end
      REG_TABLE_COUNT: tables_cfg = d[TCNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Queue up to n writes of one tile; a row end cuts the run short
  function automatic void expand_run(logic [WORD_W-1:0] value, int n);
    tile_write_t w;
    bit          row_end;
    while (n > 0 && !map_finished) begin
      w.addr  = wr_addr;
      w.value = value;
      w.done  = 1'b0;
      wr_addr = wr_addr + TILE_STEP;
      cols_left--;
      n--;
      row_end = (cols_left == 0);
      if (row_end) begin
        cols_left = COLUMNS;
        wr_addr   = wr_addr - ROW_STEP;
        rows_left--;
        if (rows_left == 0) begin
          table_idx++;
          if (table_idx >= tables_in_map()) begin
            map_finished = 1'b1;
            w.done       = 1'b1;
          end else begin
            rows_left = rows_in_table();
            wr_addr   = base_addr + ADDR_W'(table_idx << TABLE_SHIFT);
          end
        end
      end
      w.last = row_end || (n == 0);
      expected_writes.push_back(w);
      if (row_end) break;
    end
  endfunction

  function automatic void decode_word(logic [WORD_W-1:0] word, logic restart);
    if (restart) restart_map();
    if (map_finished) return;
    untouched = 1'b0;
    case (phase)
      EXPECT_VALUE: begin
        held_tile = word;
        phase     = EXPECT_COUNT;
      end
      EXPECT_COUNT: begin
        phase = EXPECT_TOKEN;
        expand_run(held_tile, int'(word) + 1);
      end
      default: begin
        if (word == '0) phase = EXPECT_VALUE;
        else expand_run(word, 1);
      end
    endcase
  endfunction

  function automatic void check_write();
    tile_write_t       want;
    logic [ADDR_W-1:0] got_addr;
    logic [WORD_W-1:0] got_value;
    got_addr  = m_axis_tdata[15:0];
    got_value = m_axis_tdata[31:16];
    checked_cnt++;
    if (expected_writes.size() == 0) begin
      $error("unexpected tile write: tile_addr %h tile_value %h", got_addr, got_value);
      mismatch_cnt++;
      return;
    end
    want = expected_writes.pop_front();
    if (got_addr !== want.addr) begin
      $error("tile_addr: expected %h, got %h", want.addr, got_addr);
      mismatch_cnt++;
    end
    if (got_value !== want.value) begin
      $error("tile_value: expected %h, got %h", want.value, got_value);
      mismatch_cnt++;
    end
    if (m_axis_tlast !== want.last) begin
      $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
      mismatch_cnt++;
    end
    if (m_axis_tuser !== want.done) begin
      $error("map_done: expected %b, got %b", want.done, m_axis_tuser);
      mismatch_cnt++;
    end
  endfunction

  // Register writes, then input beats, then output beats of the same edge
  always @(posedge clk) begin
    if (rst) begin
      base_addr  = DEST_BASE_RST;
      rows_cfg   = ROWS_PER_TABLE_RST;
      tables_cfg = TABLE_COUNT_RST;
      restart_map();
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_reg_t'(cfg_index), cfg_data);
      if (s_axis_tvalid && s_axis_tready) decode_word(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_write();
    end
    fail_count     <= mismatch_cnt;
    writes_pending <= expected_writes.size();
    writes_checked <= checked_cnt;
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import tmrle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 10;
  localparam int RANDOM_PHASES  = 8;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;   // [15:0] rom_word
  logic                 s_axis_tuser  = 1'b0; // [0] start_map
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;         // [15:0] tile_addr, [31:16] tile_value
  logic                 m_axis_tlast;         // last_of_run
  logic                 m_axis_tuser;         // [0] map_done
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [WORD_W-1:0]    cfg_data      = '0;

  int fail_count;
  int writes_pending;
  int writes_checked;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int words_fed     = 0;
  int settings_used = 0;
  int idle_cycles   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tilemap_rle_nametable_loader_core i_dut (.*);

  tile_write_checker i_checker (.*);

  // Receiver stalls
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: cycles in a row with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_pacing(input int mode);
    case (mode)
      1:       begin idle_pct = 48; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 48; end
      3:       begin idle_pct = 18; stall_pct = 18; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input bit [2:0] sel, input logic [15:0] dest,
                           input logic [7:0] rows, input logic [2:0] tables);
    if (sel[0]) write_reg(REG_DEST_BASE, dest);
    if (sel[1]) write_reg(REG_ROWS_PER_TABLE, {8'h00, rows});
    if (sel[2]) write_reg(REG_TABLE_COUNT, {13'h0000, tables});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // One ROM word beat; valid stays up when the next word follows at once
  task automatic feed_word(input logic [15:0] w, input bit restart);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= restart;
    do @(posedge clk); while (!s_axis_tready);
    words_fed++;
  endtask

  // Escape token, tile value, count
  task automatic feed_run(input logic [15:0] value, input logic [15:0] count,
                          input bit restart);
    feed_word(16'h0000, restart);
    feed_word(value, 1'b0);
    feed_word(count, 1'b0);
  endtask

  // Let every predicted write drain, then wait out a word still in decode
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (writes_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int p);
    bit          first;
    int          sent;
    int          pick;
    logic [7:0]  rows;
    logic [15:0] value;
    logic [15:0] count;
    settle();
    set_pacing(p % 4);
    rows = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    case (p)
      0:       configure(3'b111, 16'hFFFF, 8'd255, 3'd7);
      1:       configure(3'b111, 16'($urandom), 8'd2, 3'd1);
      default: configure(3'($urandom_range(0, 7)), 16'($urandom), rows,
                         3'($urandom_range(0, 7)));
    endcase
    first = (p < 2) || ($urandom_range(0, 3) != 0);
    sent  = 0;
    while (sent < PHASE_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        feed_word(16'($urandom_range(1, 65535)), first);
        sent += 1;
      end else if (pick < 85) begin
        value = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
        pick  = $urandom_range(0, 9);
        count = (pick < 7) ? 16'($urandom_range(0, 7)) :
                (pick < 9) ? 16'($urandom_range(8, 70)) : 16'($urandom);
        feed_run(value, count, first);
        sent += 3;
      end else if (pick < 95) begin
        feed_word(16'($urandom), first);
        sent += 1;
      end else begin
        feed_word(16'($urandom_range(1, 65535)), 1'b1);
        sent += 1;
      end
      first = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Single-row, single-table map placed to wrap past the top of tile RAM
    configure(3'b111, 16'hFFF0, 8'd0, 3'd0);
    feed_word(16'h0001, 1'b0);
    feed_word(16'hFFFF, 1'b0);
    feed_run(16'h0000, 16'h0000, 1'b0);
    // Longest count: cut at the row end, which also completes the map
    feed_run(16'hA5A5, 16'hFFFF, 1'b0);
    // Words after completion give nothing until a restart
    feed_word(16'h1234, 1'b0);
    feed_word(16'h0000, 1'b0);
    feed_word(16'h5A5A, 1'b1);
    feed_run(16'h7E7E, 16'd2, 1'b0);

    // One row per table; lower the table count after two tables are full
    settle();
    set_pacing(3);
    configure(3'b111, 16'h0000, 8'd1, 3'd4);
    feed_run(16'h1111, 16'd63, 1'b1);
    feed_run(16'h2222, 16'd63, 1'b0);
    settle();
    configure(3'b100, 16'h0000, 8'd0, 3'd2);
    feed_word(16'h3333, 1'b0);
    feed_run(16'h4444, 16'd100, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);
    settle();

    $display("Fed %0d ROM words under %0d register settings and four pacing mixes;",
             words_fed, settings_used);
    $display("%0d tile writes compared against the predicted address and value stream.",
             writes_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
